[design/bnf_pkg.sv]
// Shared types and constants for the batch normalization forward block.
package bnf_pkg;

    localparam int FEATURES_DEF = 256;

    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 168;
    localparam int CFG_W      = 32;

    localparam logic [1:0] OP_MEAN = 2'd0;
    localparam logic [1:0] OP_VAR  = 2'd1;
    localparam logic [1:0] OP_NORM = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [1:0] REG_TRAIN    = 2'd0;
    localparam logic [1:0] REG_MOMENTUM = 2'd1;
    localparam logic [1:0] REG_EPSILON  = 2'd2;

    localparam logic [16:0] MOMENTUM_RST = 17'd6554;
    localparam logic [31:0] EPSILON_RST  = 32'd42950;
    localparam logic [16:0] MOM_ONE      = 17'd65536;
    localparam logic [31:0] VAR_ONE      = 32'd65536;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ACC0, ST_MDIV0, ST_MDIV, ST_MFIN,
        ST_SQ, ST_ACC1, ST_VDIV0, ST_VDIV, ST_VEPS, ST_IDIV0, ST_IDIV,
        ST_SQ0, ST_SQRT, ST_IFIN, ST_UDIV0, ST_UDIV, ST_UFIN,
        ST_BLA, ST_BLB, ST_BLC, ST_BLD, ST_BLW, ST_EVV,
        ST_NM1, ST_NM2, ST_NM3, ST_NM4, ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        C_NONE, C_CLEAR, C_LOAD, C_ACC0, C_DIVM, C_DSTEP, C_MFIN,
        C_SQ, C_ACC1, C_DIVV, C_VEPS, C_DIVI, C_SQRTI, C_SSTEP, C_IFIN,
        C_DIVU, C_UFIN, C_BLA, C_BLB, C_BLC, C_BLD, C_BLW, C_EVV,
        C_NM1, C_NM2, C_NM3, C_NM4, C_EMIT
    } cmd_t;

    typedef struct packed {
        logic       div_last;
        logic       sqrt_last;
        logic       clr_last;
        logic       out_busy;
        logic [1:0] op;
        logic       last;
        logic       train;
    } dp_status_t;

endpackage

[design/bnf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bnf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/bnf_ctrl.sv]
// Controller state machine that sequences the batch normalization datapath.
module bnf_ctrl
    import bnf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_op,
    output logic       in_ready,
    input  dp_status_t status,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_op)
                        OP_MEAN: state_next = ST_ACC0;
                        OP_VAR:  state_next = ST_SQ;
                        OP_NORM: state_next = status.train ? ST_NM1 : ST_EVV;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ACC0:  state_next = status.last ? ST_MDIV0 : ST_IDLE;
            ST_MDIV0: state_next = ST_MDIV;
            ST_MDIV:  if (status.div_last) state_next = ST_MFIN;
            ST_MFIN:  state_next = ST_EMIT;
            ST_SQ:    state_next = ST_ACC1;
            ST_ACC1:  state_next = status.last ? ST_VDIV0 : ST_IDLE;
            ST_VDIV0: state_next = ST_VDIV;
            ST_VDIV:  if (status.div_last) state_next = ST_VEPS;
            ST_VEPS:  state_next = ST_IDIV0;
            ST_IDIV0: state_next = ST_IDIV;
            ST_IDIV:  if (status.div_last) state_next = ST_SQ0;
            ST_SQ0:   state_next = ST_SQRT;
            ST_SQRT:  if (status.sqrt_last) state_next = ST_IFIN;
            ST_IFIN:  state_next = (status.op == OP_VAR) ? ST_UDIV0 : ST_NM1;
            ST_UDIV0: state_next = ST_UDIV;
            ST_UDIV:  if (status.div_last) state_next = ST_UFIN;
            ST_UFIN:  state_next = ST_BLA;
            ST_BLA:   state_next = ST_BLB;
            ST_BLB:   state_next = ST_BLC;
            ST_BLC:   state_next = ST_BLD;
            ST_BLD:   state_next = ST_BLW;
            ST_BLW:   state_next = ST_EMIT;
            ST_EVV:   state_next = ST_IDIV0;
            ST_NM1:   state_next = ST_NM2;
            ST_NM2:   state_next = ST_NM3;
            ST_NM3:   state_next = ST_NM4;
            ST_NM4:   state_next = ST_EMIT;
            ST_EMIT:  if (!status.out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = C_NONE;
        unique case (state_reg)
            ST_CLEAR: cmd = C_CLEAR;
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd = C_LOAD;
            end
            ST_ACC0:  cmd = C_ACC0;
            ST_MDIV0: cmd = C_DIVM;
            ST_MDIV:  cmd = C_DSTEP;
            ST_MFIN:  cmd = C_MFIN;
            ST_SQ:    cmd = C_SQ;
            ST_ACC1:  cmd = C_ACC1;
            ST_VDIV0: cmd = C_DIVV;
            ST_VDIV:  cmd = C_DSTEP;
            ST_VEPS:  cmd = C_VEPS;
            ST_IDIV0: cmd = C_DIVI;
            ST_IDIV:  cmd = C_DSTEP;
            ST_SQ0:   cmd = C_SQRTI;
            ST_SQRT:  cmd = C_SSTEP;
            ST_IFIN:  cmd = C_IFIN;
            ST_UDIV0: cmd = C_DIVU;
            ST_UDIV:  cmd = C_DSTEP;
            ST_UFIN:  cmd = C_UFIN;
            ST_BLA:   cmd = C_BLA;
            ST_BLB:   cmd = C_BLB;
            ST_BLC:   cmd = C_BLC;
            ST_BLD:   cmd = C_BLD;
            ST_BLW:   cmd = C_BLW;
            ST_EVV:   cmd = C_EVV;
            ST_NM1:   cmd = C_NM1;
            ST_NM2:   cmd = C_NM2;
            ST_NM3:   cmd = C_NM3;
            ST_NM4:   cmd = C_NM4;
            ST_EMIT:  if (!status.out_busy) cmd = C_EMIT;
            default:  cmd = C_NONE;
        endcase
    end

endmodule

[design/bnf_dp.sv]
// Datapath: accumulators, shared divider and root unit, running statistics, output register.
module bnf_dp
    import bnf_pkg::*;
#(
    parameter int FEATURES = FEATURES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output dp_status_t         status,
    input  logic               cfg_wen,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [1:0]         in_op,
    input  logic [7:0]         in_feature,
    input  logic [31:0]        in_sample,
    input  logic [31:0]        in_weight,
    input  logic [31:0]        in_bias,
    input  logic               in_last,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [1:0]         out_kind,
    output logic [31:0]        out_normalized,
    output logic [31:0]        out_mean,
    output logic [31:0]        out_invstd,
    output logic [31:0]        out_avg_mean,
    output logic [31:0]        out_avg_var,
    output logic               out_single
);

    localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;

    localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

    function automatic logic [AW-1:0] feat_index(input logic [7:0] f);
        int v;
        v = int'(f);
        for (int k = 7; k >= 0; k--)
        begin
            if (v >= (FEATURES << k)) v = v - (FEATURES << k);
        end
        return AW'(v);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        if (v > S32_MAX) return 32'h7FFF_FFFF;
        if (v < S32_MIN) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // configuration
    logic        train_reg, train_next;
    logic [16:0] mom_reg, mom_next;
    logic [31:0] eps_reg, eps_next;
    // current item
    logic [1:0]    op_reg, op_next;
    logic          last_reg, last_next;
    logic [AW-1:0] feat_reg, feat_next;
    logic [31:0]   x_reg, x_next, w_reg, w_next, b_reg, b_next;
    // pass state
    logic [63:0] sum_reg, sum_next, dev_reg, dev_next, sq_reg, sq_next;
    logic [31:0] cnt_reg, cnt_next, mean_reg, mean_next, inv_reg, inv_next;
    // divider
    logic [63:0] num_reg, num_next, den_reg, den_next, rem_reg, rem_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    // inverse root
    logic [63:0] vv_reg, vv_next;
    logic        adj_reg, adj_next, zero_reg, zero_next;
    logic [63:0] sx_reg, sx_next, sr_reg, sr_next, sb_reg, sb_next;
    logic [4:0]  scnt_reg, scnt_next;
    // running update
    logic               single_reg, single_next;
    logic [31:0]        u32_reg, u32_next;
    logic signed [49:0] tm_reg, tm_next;
    logic [49:0]        tv_reg, tv_next;
    logic [31:0]        am_reg, am_next, av_reg, av_next;
    // normalize
    logic [47:0] p1_reg, p1_next, p2_reg, p2_next;
    logic        n1_reg, n1_next, n2_reg, n2_next;
    logic [31:0] y_reg, y_next, z_reg, z_next;
    // clearing and output
    logic [AW-1:0] clr_reg, clr_next;
    logic          ov_reg, ov_next;
    logic [1:0]    ok_reg, ok_next;
    logic [31:0]   onorm_reg, onorm_next, omean_reg, omean_next, oinv_reg, oinv_next;
    logic [31:0]   oam_reg, oam_next, oav_reg, oav_next;
    logic          osing_reg, osing_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wmean, ram_wvar, ram_mean, ram_var;

    // The read address follows the feature being loaded, so the entry is ready
    // in the cycle after the beat is taken.
    bnf_ram #(.WIDTH(32), .DEPTH(FEATURES), .AW(AW)) u_mean_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wmean),
        .raddr (feat_next),
        .rdata (ram_mean)
    );

    bnf_ram #(.WIDTH(32), .DEPTH(FEATURES), .AW(AW)) u_var_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wvar),
        .raddr (feat_next),
        .rdata (ram_var)
    );

    always_comb
    begin
        logic [64:0]        trial, s65;
        logic               ge;
        logic signed [32:0] d33;
        logic [32:0]        md;
        logic [63:0]        var64, tsq, prod;
        logic [16:0]        meff, mc;
        logic [31:0]        mean_s, inv_s, ay, aw;
        logic signed [49:0] pz, zsum, q50;

        train_next = train_reg; mom_next = mom_reg; eps_next = eps_reg;
        op_next = op_reg; last_next = last_reg; feat_next = feat_reg;
        x_next = x_reg; w_next = w_reg; b_next = b_reg;
        sum_next = sum_reg; dev_next = dev_reg; sq_next = sq_reg;
        cnt_next = cnt_reg; mean_next = mean_reg; inv_next = inv_reg;
        num_next = num_reg; den_next = den_reg; rem_next = rem_reg; dcnt_next = dcnt_reg;
        vv_next = vv_reg; adj_next = adj_reg; zero_next = zero_reg;
        sx_next = sx_reg; sr_next = sr_reg; sb_next = sb_reg; scnt_next = scnt_reg;
        single_next = single_reg; u32_next = u32_reg; tm_next = tm_reg; tv_next = tv_reg;
        am_next = am_reg; av_next = av_reg;
        p1_next = p1_reg; p2_next = p2_reg; n1_next = n1_reg; n2_next = n2_reg;
        y_next = y_reg; z_next = z_reg;
        clr_next = clr_reg;
        ok_next = ok_reg; onorm_next = onorm_reg; omean_next = omean_reg;
        oinv_next = oinv_reg; oam_next = oam_reg; oav_next = oav_reg;
        osing_next = osing_reg;
        ov_next = out_ready ? 1'b0 : ov_reg;
        ram_we = 1'b0; ram_waddr = feat_reg; ram_wmean = am_reg; ram_wvar = av_reg;

        meff  = (mom_reg > MOM_ONE) ? MOM_ONE : mom_reg;
        mc    = MOM_ONE - meff;
        trial = {rem_reg, num_reg[63]};
        ge    = trial >= {1'b0, den_reg};
        d33   = 33'(signed'(x_reg)) - 33'(signed'(mean_reg));
        md    = d33[32] ? 33'(-d33) : 33'(d33);
        tsq   = sr_reg + sb_reg;
        mean_s = train_reg ? mean_reg : ram_mean;
        inv_s  = train_reg ? inv_reg : sr_reg[31:0];
        ay    = y_reg[31] ? 32'(-y_reg) : y_reg;
        aw    = w_reg[31] ? 32'(-w_reg) : w_reg;
        s65   = '0; var64 = '0; prod = '0; pz = '0; zsum = '0; q50 = '0;

        if (cfg_wen)
        begin
            if (cfg_index == REG_TRAIN)    train_next = cfg_data[0];
            if (cfg_index == REG_MOMENTUM) mom_next = cfg_data[16:0];
            if (cfg_index == REG_EPSILON)  eps_next = cfg_data;
        end

        case (cmd)
            C_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wmean = '0;
                ram_wvar  = VAR_ONE;
                clr_next  = clr_reg + AW'(1);
            end
            C_LOAD:
            begin
                op_next = in_op; last_next = in_last; feat_next = feat_index(in_feature);
                x_next = in_sample; w_next = in_weight; b_next = in_bias;
            end
            C_ACC0:
            begin
                sum_next = sum_reg + {{32{x_reg[31]}}, x_reg};
                cnt_next = cnt_reg + 32'd1;
            end
            C_DIVM:
            begin
                num_next = sum_reg[63] ? 64'(-sum_reg) : sum_reg;
                den_next = {32'd0, cnt_reg}; rem_next = '0; dcnt_next = '0;
            end
            C_DSTEP:
            begin
                rem_next  = ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
                num_next  = {num_reg[62:0], ge};
                dcnt_next = dcnt_reg + 6'd1;
            end
            C_MFIN:
            begin
                if (cnt_reg == 32'd0) mean_next = '0;
                else if (!sum_reg[63])
                    mean_next = (num_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_reg[31:0];
                else
                    mean_next = (num_reg > 64'h8000_0000) ? 32'h8000_0000
                                                          : 32'(-num_reg[31:0]);
                sum_next = '0; cnt_next = '0;
            end
            C_SQ: sq_next = 64'(md * md);
            C_ACC1:
            begin
                s65 = {1'b0, dev_reg} + {1'b0, sq_reg};
                dev_next = s65[64] ? '1 : s65[63:0];
                cnt_next = cnt_reg + 32'd1;
            end
            C_DIVV:
            begin
                num_next = dev_reg; den_next = {32'd0, cnt_reg};
                rem_next = '0; dcnt_next = '0;
            end
            C_VEPS:
            begin
                var64 = (cnt_reg == 32'd0) ? 64'd0 : num_reg;
                s65 = {1'b0, var64} + {33'd0, eps_reg};
                vv_next = s65[64] ? '1 : s65[63:0];
                zero_next = (dev_reg == 64'd0) && (eps_reg == 32'd0);
            end
            C_DIVI:
            begin
                num_next = '1; den_next = vv_reg; rem_next = '0; dcnt_next = '0;
                // an exact power of two divides all-ones one short of the true quotient
                adj_next = (vv_reg > 64'd1) && ((vv_reg & (vv_reg - 64'd1)) == 64'd0);
            end
            C_SQRTI:
            begin
                sx_next = num_reg + {63'd0, adj_reg};
                sr_next = '0; sb_next = 64'd1 << 62; scnt_next = '0;
            end
            C_SSTEP:
            begin
                if (sx_reg >= tsq)
                begin
                    sx_next = sx_reg - tsq;
                    sr_next = (sr_reg >> 1) + sb_reg;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sb_next = sb_reg >> 2;
                scnt_next = scnt_reg + 5'd1;
            end
            C_IFIN:
            begin
                if (op_reg == OP_VAR) inv_next = zero_reg ? 32'd0 : sr_reg[31:0];
            end
            C_DIVU:
            begin
                num_next = dev_reg; den_next = {32'd0, cnt_reg - 32'd1};
                rem_next = '0; dcnt_next = '0;
                single_next = cnt_reg < 32'd2;
            end
            C_UFIN: u32_next = (num_reg[63:48] != 16'd0) ? '1 : num_reg[47:16];
            C_BLA: tm_next = $signed({1'b0, meff}) * $signed(mean_reg);
            C_BLB: tm_next = tm_reg + $signed({1'b0, mc}) * $signed(ram_mean) + 50'sd32768;
            C_BLC:
            begin
                q50 = tm_reg >>> 16;
                am_next = sat32(q50);
                tv_next = 50'(meff * u32_reg);
            end
            C_BLD: tv_next = tv_reg + 50'(mc * ram_var) + 50'd32768;
            C_BLW:
            begin
                av_next   = single_reg ? ram_var : tv_reg[47:16];
                ram_we    = 1'b1;
                ram_wmean = am_reg;
                ram_wvar  = av_next;
                dev_next  = '0; cnt_next = '0;
            end
            C_EVV:
            begin
                vv_next = {16'd0, ram_var, 16'd0} + {32'd0, eps_reg};
            end
            C_NM1:
            begin
                d33  = 33'(signed'(x_reg)) - 33'(signed'(mean_s));
                md   = d33[32] ? 33'(-d33) : 33'(d33);
                prod = 64'(md * inv_s);
                p1_next = 48'((prod + 64'd32768) >> 16);
                n1_next = d33[32];
            end
            C_NM2:
            begin
                if (n1_reg)
                    y_next = (p1_reg > 48'h8000_0000) ? 32'h8000_0000 : 32'(-p1_reg[31:0]);
                else
                    y_next = (p1_reg > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : p1_reg[31:0];
            end
            C_NM3:
            begin
                prod = 64'(ay * aw);
                p2_next = 48'((prod + 64'd32768) >> 16);
                n2_next = y_reg[31] ^ w_reg[31];
            end
            C_NM4:
            begin
                pz = $signed({2'b00, p2_reg});
                zsum = (n2_reg ? -pz : pz) + $signed({{18{b_reg[31]}}, b_reg});
                z_next = sat32(zsum);
            end
            C_EMIT:
            begin
                ov_next = 1'b1;
                ok_next = op_reg;
                onorm_next = (op_reg == OP_NORM) ? z_reg : 32'd0;
                omean_next = (op_reg == OP_NORM) ? 32'd0 : mean_reg;
                oinv_next  = (op_reg == OP_VAR) ? inv_reg : 32'd0;
                oam_next   = (op_reg == OP_VAR) ? am_reg : 32'd0;
                oav_next   = (op_reg == OP_VAR) ? av_reg : 32'd0;
                osing_next = (op_reg == OP_VAR) && single_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_reg <= 1'b1;
            mom_reg   <= MOMENTUM_RST;
            eps_reg   <= EPSILON_RST;
            op_reg    <= OP_NONE;
            last_reg  <= 1'b0;
            sum_reg   <= '0;
            dev_reg   <= '0;
            cnt_reg   <= '0;
            mean_reg  <= '0;
            inv_reg   <= '0;
            dcnt_reg  <= '0;
            scnt_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            train_reg <= train_next;
            mom_reg   <= mom_next;
            eps_reg   <= eps_next;
            op_reg    <= op_next;
            last_reg  <= last_next;
            sum_reg   <= sum_next;
            dev_reg   <= dev_next;
            cnt_reg   <= cnt_next;
            mean_reg  <= mean_next;
            inv_reg   <= inv_next;
            dcnt_reg  <= dcnt_next;
            scnt_reg  <= scnt_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        feat_reg <= feat_next; x_reg <= x_next; w_reg <= w_next; b_reg <= b_next;
        sq_reg <= sq_next;
        num_reg <= num_next; den_reg <= den_next; rem_reg <= rem_next;
        vv_reg <= vv_next; adj_reg <= adj_next; zero_reg <= zero_next;
        sx_reg <= sx_next; sr_reg <= sr_next; sb_reg <= sb_next;
        single_reg <= single_next; u32_reg <= u32_next;
        tm_reg <= tm_next; tv_reg <= tv_next; am_reg <= am_next; av_reg <= av_next;
        p1_reg <= p1_next; p2_reg <= p2_next; n1_reg <= n1_next; n2_reg <= n2_next;
        y_reg <= y_next; z_reg <= z_next;
        ok_reg <= ok_next; onorm_reg <= onorm_next; omean_reg <= omean_next;
        oinv_reg <= oinv_next; oam_reg <= oam_next; oav_reg <= oav_next;
        osing_reg <= osing_next;
    end

    assign status.div_last  = (dcnt_reg == 6'd63);
    assign status.sqrt_last = (scnt_reg == 5'd31);
    assign status.clr_last  = (clr_reg == AW'(FEATURES - 1));
    assign status.out_busy  = ov_reg && !out_ready;
    assign status.op        = op_reg;
    assign status.last      = last_reg;
    assign status.train     = train_reg;

    assign out_valid      = ov_reg;
    assign out_kind       = ok_reg;
    assign out_normalized = onorm_reg;
    assign out_mean       = omean_reg;
    assign out_invstd     = oinv_reg;
    assign out_avg_mean   = oam_reg;
    assign out_avg_var    = oav_reg;
    assign out_single     = osing_reg;

endmodule

[design/batch_norm_forward.sv]
// Top level of the batch normalization forward block (Q16.16 fixed point).
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         tvalid/tready      tuser=operation, tlast=last_sample,
//                                          tdata=feature,sample,scale_weight,shift_bias
//   m_*      out        tvalid/tready      tuser=result_kind, tdata=normalized,batch_mean,
//                                          batch_invstd,avg_mean,avg_variance,single_sample
//   cfg_*    in         cfg_wen only       cfg_index selects train_mode/momentum/epsilon
//
// A mean beat that does not end its pass is added to the sum; a variance beat is squared
// and added to the deviation sum. The final mean beat and the final variance beat both
// run the shared one-bit-per-cycle 64-bit divider, and the variance pass also runs a
// 32-step inverse root and a further division for the unbiased variance. A normalize
// beat in training mode uses the batch statistics; in eval mode the inverse root of
// the running variance is recomputed through the divider. After reset a clearing pass
// loads every entry of the running statistics tables (mean 0, variance 1.0); no beat is
// accepted until it ends, configuration writes are. One beat is worked at a time; a
// finished result waits in the output register, so a stalled output only holds the
// block when the next result is ready to be written.
module batch_norm_forward
    import bnf_pkg::*;
#(
    parameter int FEATURES = FEATURES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // feature[7:0], sample[39:8], scale_weight[71:40], shift_bias[103:72]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // normalized[31:0], batch_mean[63:32], batch_invstd[95:64], avg_mean[127:96],
    // avg_variance[159:128], single_sample[160], zero fill[167:161]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // result_kind[1:0]
    output logic [1:0]            m_tuser,
    input  logic                  cfg_wen,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t       cmd;
    dp_status_t status;
    logic [31:0] o_norm, o_mean, o_inv, o_am, o_av;
    logic        o_single;

    bnf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bnf_dp #(.FEATURES(FEATURES)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_op          (s_tuser),
        .in_feature     (s_tdata[7:0]),
        .in_sample      (s_tdata[39:8]),
        .in_weight      (s_tdata[71:40]),
        .in_bias        (s_tdata[103:72]),
        .in_last        (s_tlast),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_kind       (m_tuser),
        .out_normalized (o_norm),
        .out_mean       (o_mean),
        .out_invstd     (o_inv),
        .out_avg_mean   (o_am),
        .out_avg_var    (o_av),
        .out_single     (o_single)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tdata = {7'd0, o_single, o_av, o_am, o_inv, o_mean, o_norm};

endmodule

[design/bnf_check.sv]
// Port-level checker for the batch normalization forward block, with its bind.
module bnf_check
    import bnf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [1:0]            s_tuser,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [1:0]            m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_norm_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OP_NORM) |-> (m_tdata[OUT_DATA_W-1:32] == '0))
        else $error("normalized beat carries statistics fields");

    a_mean_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == OP_MEAN) |->
            (m_tdata[31:0] == 32'd0) && (m_tdata[OUT_DATA_W-1:64] == '0))
        else $error("mean beat carries other fields");

    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_MEAN) && !s_tlast |=> !$rose(m_tvalid))
        else $error("result produced for a beat inside a pass");

endmodule

bind batch_norm_forward bnf_check u_bnf_check (.*);

[bench/tb_top.sv]
// Self-checking bench for the batch normalization forward block.
`timescale 1ns / 1ps

module tb_top;
    import bnf_pkg::*;

    localparam int NF = FEATURES_DEF;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // feature[7:0], sample[39:8], scale_weight[71:40], shift_bias[103:72]
    logic [IN_DATA_W-1:0]  s_tdata;
    // operation[1:0]
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    // normalized[31:0], batch_mean[63:32], batch_invstd[95:64], avg_mean[127:96],
    // avg_variance[159:128], single_sample[160]
    logic [OUT_DATA_W-1:0] m_tdata;
    // result_kind[1:0]
    logic [1:0]            m_tuser;
    logic                  cfg_wen;
    logic [1:0]            cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] normalized;
        logic [31:0] mean;
        logic [31:0] invstd;
        logic [31:0] run_mean;
        logic [31:0] run_var;
        logic        single;
    } bn_result_t;

    // Predictor copy of the block's configuration and state.
    logic        p_train;
    logic [16:0] p_momentum;
    logic [31:0] p_epsilon;
    logic [63:0] p_sum;
    logic [63:0] p_dev;
    logic [31:0] p_count;
    logic [31:0] p_mean;
    logic [31:0] p_invstd;
    logic [31:0] p_run_mean [NF];
    logic [31:0] p_run_var [NF];

    bn_result_t expected_results [$];
    int  errors;
    bit  in_idle_en;
    bit  out_idle_en;

    batch_norm_forward u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [31:0] sat_s32(input logic signed [127:0] v);
        if (v > 128'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -128'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] bitv;
        logic [63:0] x;
        r = 0;
        x = v;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= r + bitv)
            begin
                x = x - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // floor(2^32 / sqrt(v)) with v in Q32.32, saturated to 32 bits.
    function automatic logic [31:0] recip_root(input logic [63:0] v);
        logic [63:0] q;
        logic [63:0] r;
        if (v == 0)
            return 32'hFFFF_FFFF;
        q = 64'hFFFF_FFFF_FFFF_FFFF / v;
        if (v > 1 && (v & (v - 1)) == 0)
            q = q + 1;
        r = root64(q);
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    // Q16.16 product rounded half away from zero.
    function automatic logic signed [127:0] qmul(input logic signed [127:0] a,
                                                 input logic signed [127:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb + 128'd32768) >> 16;
        return ((a < 0) != (b < 0)) ? -$signed(p) : $signed(p);
    endfunction

    function automatic logic [16:0] momentum_used();
        return (p_momentum > MOM_ONE) ? MOM_ONE : p_momentum;
    endfunction

    function automatic logic [31:0] blend_mean(input logic [31:0] now_v,
                                               input logic [31:0] old_v);
        logic signed [127:0] m;
        logic signed [127:0] t;
        m = momentum_used();
        t = m * $signed(now_v) + (128'sd65536 - m) * $signed(old_v) + 128'sd32768;
        return sat_s32(t >>> 16);
    endfunction

    function automatic logic [31:0] blend_var(input logic [31:0] now_v,
                                              input logic [31:0] old_v);
        logic [63:0] m;
        logic [63:0] t;
        m = momentum_used();
        t = m * now_v + (64'd65536 - m) * old_v + 64'd32768;
        return t[47:16];
    endfunction

    task automatic model_reset();
        p_train = 1'b1;
        p_momentum = MOMENTUM_RST;
        p_epsilon = EPSILON_RST;
        p_sum = 0;
        p_dev = 0;
        p_count = 0;
        p_mean = 0;
        p_invstd = 0;
        for (int i = 0; i < NF; i++)
        begin
            p_run_mean[i] = 0;
            p_run_var[i] = VAR_ONE;
        end
    endtask

    // Advances the predictor by one accepted beat and queues any result.
    task automatic predict_beat(input logic [1:0] op, input logic [7:0] feat,
                                input logic [31:0] x, input logic [31:0] w,
                                input logic [31:0] b, input logic last);
        bn_result_t r;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] d;
        logic [63:0] sq;
        logic [63:0] var_v;
        logic [63:0] vv;
        logic [63:0] u;
        logic signed [127:0] dm;
        logic signed [127:0] y;
        logic signed [127:0] z;
        logic [31:0] mean_v;
        logic [31:0] inv_v;
        logic neg;
        r = '0;
        if (op == OP_NONE)
            return;
        if (op == OP_MEAN)
        begin
            p_sum = p_sum + {{32{x[31]}}, x};
            p_count = p_count + 1;
            if (!last)
                return;
            neg = p_sum[63];
            mag = neg ? -p_sum : p_sum;
            q = (p_count != 0) ? mag / p_count : 0;
            if (q > 64'h1_0000_0000)
                q = 64'h1_0000_0000;
            p_mean = neg ? sat_s32(-$signed({64'd0, q})) : sat_s32($signed({64'd0, q}));
            p_sum = 0;
            p_count = 0;
            r.kind = OP_MEAN;
            r.mean = p_mean;
        end
        else if (op == OP_VAR)
        begin
            dm = $signed(x) - $signed(p_mean);
            d = dm < 0 ? -dm[63:0] : dm[63:0];
            sq = d * d;
            p_dev = (p_dev > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : p_dev + sq;
            p_count = p_count + 1;
            if (!last)
                return;
            var_v = (p_count != 0) ? p_dev / p_count : 0;
            vv = (var_v > 64'hFFFF_FFFF_FFFF_FFFF - p_epsilon) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                               : var_v + p_epsilon;
            p_invstd = (p_dev == 0 && p_epsilon == 0) ? 32'd0 : recip_root(vv);
            p_run_mean[feat] = blend_mean(p_mean, p_run_mean[feat]);
            r.single = p_count < 2;
            if (!r.single)
            begin
                u = (p_dev / (p_count - 1)) >> 16;
                p_run_var[feat] = blend_var(u > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : u[31:0],
                                            p_run_var[feat]);
            end
            r.kind = OP_VAR;
            r.mean = p_mean;
            r.invstd = p_invstd;
            r.run_mean = p_run_mean[feat];
            r.run_var = p_run_var[feat];
            p_dev = 0;
            p_count = 0;
        end
        else
        begin
            if (p_train)
            begin
                mean_v = p_mean;
                inv_v = p_invstd;
            end
            else
            begin
                mean_v = p_run_mean[feat];
                inv_v = recip_root({16'd0, p_run_var[feat], 16'd0} + p_epsilon);
            end
            y = $signed(sat_s32(qmul($signed(x) - $signed(mean_v), {96'd0, inv_v})));
            z = qmul(y, $signed(w)) + $signed(b);
            r.kind = OP_NORM;
            r.normalized = sat_s32(z);
        end
        expected_results.push_back(r);
    endtask

    // Sends one beat, with a random idle burst ahead of it when enabled.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] feat,
                             input logic [31:0] x, input logic [31:0] w,
                             input logic [31:0] b, input logic last);
        if (in_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tlast <= last;
        s_tdata <= {b, w, x, feat};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beat(op, feat, x, w, b, last);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until all results are back, then lets an end-of-pass result settle.
    task automatic drain();
        drop_valid();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        if (idx == REG_TRAIN)
            p_train = val[0];
        else if (idx == REG_MOMENTUM)
            p_momentum = val[16:0];
        else
            p_epsilon = val;
    endtask

    function automatic logic [31:0] rand_q(input int spread);
        case ($urandom_range(0, 3))
            0: return $urandom();
            default: return $signed($urandom_range(0, spread)) - spread / 2;
        endcase
    endfunction

    // One full training plane: mean pass, variance pass, normalize pass.
    task automatic send_plane(input logic [7:0] feat, input int n, input bit wide);
        logic [31:0] xs [$];
        logic [31:0] w;
        logic [31:0] b;
        for (int i = 0; i < n; i++)
            xs.push_back(wide ? $urandom() : rand_q(32'h0008_0000));
        w = ($urandom_range(0, 2) == 0) ? 32'h0001_0000 : rand_q(32'h0004_0000);
        b = ($urandom_range(0, 2) == 0) ? 32'h0 : $urandom();
        for (int i = 0; i < n; i++)
            send_beat(OP_MEAN, feat, xs[i], $urandom(), $urandom(), i == n - 1);
        for (int i = 0; i < n; i++)
            send_beat(OP_VAR, feat, xs[i], $urandom(), $urandom(), i == n - 1);
        for (int i = 0; i < n; i++)
            send_beat(OP_NORM, feat, xs[i], w, b, i == n - 1);
    endtask

    task automatic test_directed_extremes();
        // Zero spread with zero epsilon gives invstd 0.
        write_reg(REG_EPSILON, 32'd0);
        send_beat(OP_MEAN, 8'd0, 32'h0003_0000, 32'h0, 32'h0, 1'b0);
        send_beat(OP_MEAN, 8'd0, 32'h0003_0000, 32'h0, 32'h0, 1'b1);
        send_beat(OP_VAR, 8'd0, 32'h0003_0000, 32'h0, 32'h0, 1'b0);
        send_beat(OP_VAR, 8'd0, 32'h0003_0000, 32'h0, 32'h0, 1'b1);
        send_beat(OP_NORM, 8'd0, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 1'b1);
        // Single-sample plane on the top feature, with extreme values.
        send_beat(OP_MEAN, 8'hFF, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        send_beat(OP_VAR, 8'hFF, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
        // Unknown operation is ignored.
        send_beat(OP_NONE, 8'hAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_beat(OP_NORM, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_beat(OP_NORM, 8'hFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        // Wide spread drives large squared deviations into the deviation sum.
        send_beat(OP_MEAN, 8'h55, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_beat(OP_MEAN, 8'h55, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        send_beat(OP_VAR, 8'h55, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0);
        send_beat(OP_VAR, 8'h55, 32'h8000_0000, 32'h0, 32'h0, 1'b1);
        send_beat(OP_NORM, 8'h55, 32'h8000_0000, 32'hFFFF_0000, 32'h0, 1'b1);
        drain();
        write_reg(REG_EPSILON, 32'hFFFF_FFFF);
        write_reg(REG_MOMENTUM, 32'h1FFFF);
        send_plane(8'hAA, 3, 1'b1);
        drain();
    endtask

    task automatic test_eval_mode();
        write_reg(REG_TRAIN, 32'd0);
        for (int i = 0; i < 40; i++)
            send_beat(OP_NORM, 8'($urandom_range(0, 255)), rand_q(32'h0010_0000),
                      rand_q(32'h0004_0000), rand_q(32'h0004_0000),
                      1'($urandom_range(0, 1)));
        drain();
        write_reg(REG_TRAIN, 32'd1);
    endtask

    task automatic test_random_planes(input int beats);
        int sent;
        int n;
        sent = 0;
        while (sent < beats)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            if ($urandom_range(0, 7) == 0)
            begin
                // Broken stream: random operations with random last flags.
                for (int i = 0; i < n; i++)
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                              $urandom(), $urandom(), 1'($urandom_range(0, 1)));
                send_beat(OP_MEAN, 8'd1, 32'h0, 32'h0, 32'h0, 1'b1);
                send_beat(OP_VAR, 8'd1, 32'h0, 32'h0, 32'h0, 1'b1);
            end
            else
                send_plane(8'($urandom()), n, $urandom_range(0, 4) == 0);
            sent = sent + 3 * n;
        end
        drain();
    endtask

    task automatic test_settings_sweep();
        write_reg(REG_MOMENTUM, 32'd0);
        write_reg(REG_EPSILON, 32'd1);
        test_random_planes(90);
        write_reg(REG_MOMENTUM, 32'd65536);
        write_reg(REG_EPSILON, 32'd42950);
        test_random_planes(90);
        write_reg(REG_MOMENTUM, $urandom_range(0, 65536));
        write_reg(REG_EPSILON, $urandom());
        test_eval_mode();
        write_reg(REG_MOMENTUM, 32'd6554);
        test_random_planes(300);
        // Final stretch with no idling on either side.
        in_idle_en = 1'b0;
        out_idle_en = 1'b0;
        test_random_planes(120);
    endtask

    // Output ready with random stall bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (out_idle_en && $urandom_range(0, 3) == 0)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    // Compares each output beat with the oldest queued result.
    always @(posedge clk)
    begin
        bn_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result beat kind %0d", m_tuser);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser !== exp_r.kind)
                begin
                    $error("result_kind exp %0d got %0d", exp_r.kind, m_tuser);
                    errors++;
                end
                if (m_tdata[31:0] !== exp_r.normalized)
                begin
                    $error("normalized exp %h got %h", exp_r.normalized, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_r.mean)
                begin
                    $error("batch_mean exp %h got %h", exp_r.mean, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== exp_r.invstd)
                begin
                    $error("batch_invstd exp %h got %h", exp_r.invstd, m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[127:96] !== exp_r.run_mean)
                begin
                    $error("avg_mean exp %h got %h", exp_r.run_mean, m_tdata[127:96]);
                    errors++;
                end
                if (m_tdata[159:128] !== exp_r.run_var)
                begin
                    $error("avg_variance exp %h got %h", exp_r.run_var, m_tdata[159:128]);
                    errors++;
                end
                if (m_tdata[160] !== exp_r.single)
                begin
                    $error("single_sample exp %0d got %0d", exp_r.single, m_tdata[160]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        in_idle_en = 1'b1;
        out_idle_en = 1'b1;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_MEAN;
        s_tlast = 1'b0;
        cfg_wen = 1'b0;
        cfg_index = REG_TRAIN;
        cfg_data = '0;
        model_reset();
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_eval_mode();
        test_settings_sweep();
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
